// File: hdl/afcs_pkg.sv
// ----------------------------------------------------------------------------
// afcs_pkg
// Shared types and constants of the ADC frame channel statistics block.
// ----------------------------------------------------------------------------
package afcs_pkg;

  localparam int WordW    = 32;
  localparam int SampleW  = 24;
  localparam int TagW     = 8;
  localparam int ByteCntW = 16;
  localparam int WordCntW = 14;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int QueueDepthDefault = 4;

  localparam logic [WordW-1:0]  SyncWord        = 32'hFFFF_FFFF;
  localparam logic [TagW-1:0]   ChannelIdReset  = 8'hEA;
  localparam logic [ByteCntW-1:0] MaxBytesReset = 16'd1500;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgChannelId    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFrameBytes = 2'd1;

  // Result kinds
  localparam logic KindSample  = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Work request handed from the parser to the statistics engine
  typedef struct packed {
    logic                      has_sample;
    logic                      is_last;
    logic signed [SampleW-1:0] sample;
  } cmd_t;

endpackage

// File: hdl/adc_frame_channel_stats.sv
// ----------------------------------------------------------------------------
// adc_frame_channel_stats
// ADC capture deframer with per-channel top-two maximum and minimum tracking.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Carries
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_ready  | stream_word, end_of_stream
//  out_    | output    | out_valid/out_ready| item_kind, sample, four stats, last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (16 bits)
//
//  One input word is taken per clock while the request queue has room.
//  A word that yields a result presents it through the request queue and the result register; a kept
//  sample on the last word yields two results, the sample and then the summary.
//  Reset (synchronous, rst_n low) restores channel id 0xEA, limit 1500 bytes,
//  hunting state and zero statistics; no clearing pass is needed.
//  A stall on out_ready backs up the queue; in_ready drops only when it fills.
//
module adc_frame_channel_stats #(
  parameter int QUEUE_DEPTH = afcs_pkg::QueueDepthDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [afcs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [afcs_pkg::CfgDataW-1:0]       cfg_data,
  // capture words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [afcs_pkg::WordW-1:0]          in_stream_word,
  input  logic                                in_end_of_stream,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_item_kind,
  output logic signed [afcs_pkg::SampleW-1:0] out_sample_value,
  output logic signed [afcs_pkg::SampleW-1:0] out_first_max,
  output logic signed [afcs_pkg::SampleW-1:0] out_second_max,
  output logic signed [afcs_pkg::SampleW-1:0] out_first_min,
  output logic signed [afcs_pkg::SampleW-1:0] out_second_min,
  output logic                                out_last_of_run
);

  logic            q_full, q_not_empty, q_pop, push;
  afcs_pkg::cmd_t  push_cmd, head_cmd;
  logic            in_accept;

  // Configuration writes are registered directly and always taken
  assign cfg_ready = 1'b1;

  // Hold input only when the queue has no room for a request
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // Parse the stream and classify each word
  afcs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_accept        (in_accept),
    .in_stream_word   (in_stream_word),
    .in_end_of_stream (in_end_of_stream),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // Decouple the parser from result back-pressure
  afcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // Update statistics and emit results
  afcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_sample_value (out_sample_value),
    .out_first_max    (out_first_max),
    .out_second_max   (out_second_max),
    .out_first_min    (out_first_min),
    .out_second_min   (out_second_min),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// File: hdl/afcs_front.sv
// ----------------------------------------------------------------------------
// afcs_front
// Frame parser: hunts sync, checks header and byte count, tags payload words.
// ----------------------------------------------------------------------------
module afcs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [afcs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [afcs_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                in_accept,
  input  logic [afcs_pkg::WordW-1:0]          in_stream_word,
  input  logic                                in_end_of_stream,
  output logic                                push,
  output afcs_pkg::cmd_t                      push_cmd
);

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhCount   = 2'd2;
  localparam logic [1:0] PhPayload = 2'd3;

  logic [1:0]                       phase_r, phase_nxt;
  logic [afcs_pkg::WordCntW-1:0]    words_left_r, words_left_nxt;
  logic [afcs_pkg::TagW-1:0]        channel_id_r;
  logic [afcs_pkg::ByteCntW-1:0]    max_bytes_r;
  logic [afcs_pkg::WordCntW-1:0]    words_dec;
  logic                             tag_hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_id_r <= afcs_pkg::ChannelIdReset;
      max_bytes_r  <= afcs_pkg::MaxBytesReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        afcs_pkg::CfgChannelId:     channel_id_r <= cfg_data[afcs_pkg::TagW-1:0];
        afcs_pkg::CfgMaxFrameBytes: max_bytes_r  <= cfg_data[afcs_pkg::ByteCntW-1:0];
        default: ;
      endcase
    end
  end

  assign tag_hit   = (in_stream_word[afcs_pkg::WordW-1 -: afcs_pkg::TagW] == channel_id_r);
  assign words_dec = words_left_r - afcs_pkg::WordCntW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    push_cmd.has_sample = 1'b0;
    push_cmd.is_last    = in_end_of_stream;
    push_cmd.sample     = $signed(in_stream_word[afcs_pkg::SampleW-1:0]);
    case (phase_r)
      PhHunt: begin
        if (in_stream_word == afcs_pkg::SyncWord) phase_nxt = PhHeader;
      end
      PhHeader: begin
        phase_nxt = in_stream_word[afcs_pkg::WordW-1] ? PhHunt : PhCount;
      end
      PhCount: begin
        if (in_stream_word > {{(afcs_pkg::WordW-afcs_pkg::ByteCntW){1'b0}}, max_bytes_r}) begin
          phase_nxt = PhHunt;
        end else begin
          words_left_nxt = in_stream_word[afcs_pkg::WordCntW+1:2];
          phase_nxt      = (in_stream_word[afcs_pkg::WordCntW+1:2] != '0) ? PhPayload : PhHunt;
        end
      end
      PhPayload: begin
        push_cmd.has_sample = tag_hit;
        words_left_nxt      = words_dec;
        if (words_dec == '0) phase_nxt = PhHunt;
      end
      default: phase_nxt = PhHunt;
    endcase
    // drop any partial frame at the end of a run
    if (in_end_of_stream) begin
      phase_nxt      = PhHunt;
      words_left_nxt = '0;
    end
  end

  assign push = in_accept && (push_cmd.has_sample || push_cmd.is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PhHunt;
      words_left_r <= '0;
    end else if (in_accept) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

// File: hdl/afcs_queue.sv
// ----------------------------------------------------------------------------
// afcs_queue
// Small request queue between the parser and the statistics engine.
// ----------------------------------------------------------------------------
module afcs_queue #(
  parameter int DEPTH = afcs_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  afcs_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output afcs_pkg::cmd_t  head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  afcs_pkg::cmd_t  slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/afcs_back.sv
// ----------------------------------------------------------------------------
// afcs_back
// Statistics engine: tracks top-two max and min, drives the result register.
// ----------------------------------------------------------------------------
module afcs_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  input  afcs_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_item_kind,
  output logic signed [afcs_pkg::SampleW-1:0] out_sample_value,
  output logic signed [afcs_pkg::SampleW-1:0] out_first_max,
  output logic signed [afcs_pkg::SampleW-1:0] out_second_max,
  output logic signed [afcs_pkg::SampleW-1:0] out_first_min,
  output logic signed [afcs_pkg::SampleW-1:0] out_second_min,
  output logic                                out_last_of_run
);

  localparam int SW = afcs_pkg::SampleW;

  logic signed [SW-1:0] top_r, top_nxt, top2_r, top2_nxt;
  logic signed [SW-1:0] bot_r, bot_nxt, bot2_r, bot2_nxt;
  logic                 pend_sum_r;
  logic                 out_valid_r;
  logic                 kind_r, last_r;
  logic signed [SW-1:0] smp_r, fmax_r, smax_r, fmin_r, smin_r;
  logic                 slot_free, emit_sum, emit_smp;
  logic signed [SW-1:0] s;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = slot_free && !pend_sum_r && q_not_empty;
  assign emit_smp  = q_pop && q_cmd.has_sample;
  assign emit_sum  = slot_free && (pend_sum_r || (q_pop && !q_cmd.has_sample));
  assign s         = q_cmd.sample;

  // Top-two tracking; equal values never become the runner-up
  always_comb begin
    top_nxt  = top_r;
    top2_nxt = top2_r;
    bot_nxt  = bot_r;
    bot2_nxt = bot2_r;
    if (s > top_r) begin
      top2_nxt = top_r;
      top_nxt  = s;
    end else if (s < top_r && s > top2_r) begin
      top2_nxt = s;
    end
    if (s < bot_r) begin
      bot2_nxt = bot_r;
      bot_nxt  = s;
    end else if (s > bot_r && s < bot2_r) begin
      bot2_nxt = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= '0;
      top2_r     <= '0;
      bot_r      <= '0;
      bot2_r     <= '0;
      pend_sum_r <= 1'b0;
    end else if (emit_sum) begin
      top_r      <= '0;
      top2_r     <= '0;
      bot_r      <= '0;
      bot2_r     <= '0;
      pend_sum_r <= 1'b0;
    end else if (emit_smp) begin
      top_r      <= top_nxt;
      top2_r     <= top2_nxt;
      bot_r      <= bot_nxt;
      bot2_r     <= bot2_nxt;
      pend_sum_r <= q_cmd.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit_sum || emit_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sum) begin
      kind_r <= afcs_pkg::KindSummary;
      smp_r  <= '0;
      fmax_r <= top_r;
      smax_r <= top2_r;
      fmin_r <= bot_r;
      smin_r <= bot2_r;
      last_r <= 1'b1;
    end else if (emit_smp) begin
      kind_r <= afcs_pkg::KindSample;
      smp_r  <= s;
      fmax_r <= '0;
      smax_r <= '0;
      fmin_r <= '0;
      smin_r <= '0;
      last_r <= !q_cmd.is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = kind_r;
  assign out_sample_value = smp_r;
  assign out_first_max    = fmax_r;
  assign out_second_max   = smax_r;
  assign out_first_min    = fmin_r;
  assign out_second_min   = smin_r;
  assign out_last_of_run  = last_r;

endmodule

// File: hdl/afcs_checker.sv
// ----------------------------------------------------------------------------
// afcs_checker
// Port-level checks on the result channel of the statistics block.
// ----------------------------------------------------------------------------
module afcs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_item_kind,
  input logic signed [afcs_pkg::SampleW-1:0] out_sample_value,
  input logic signed [afcs_pkg::SampleW-1:0] out_first_max,
  input logic signed [afcs_pkg::SampleW-1:0] out_second_max,
  input logic signed [afcs_pkg::SampleW-1:0] out_first_min,
  input logic signed [afcs_pkg::SampleW-1:0] out_second_min,
  input logic                                out_last_of_run
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a summary always closes the run
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == afcs_pkg::KindSummary) |-> out_last_of_run)
    else $error("summary without last_of_run");

  // statistics are ordered and straddle zero
  a_sum_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == afcs_pkg::KindSummary) |->
      out_first_max >= out_second_max && out_second_max >= 0 &&
      out_first_min <= out_second_min && out_second_min <= 0 &&
      out_sample_value == 0)
    else $error("summary statistics out of order");

  // a sample result carries no statistics
  a_smp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == afcs_pkg::KindSample) |->
      out_first_max == 0 && out_second_max == 0 &&
      out_first_min == 0 && out_second_min == 0)
    else $error("sample result carries statistics");

endmodule

bind adc_frame_channel_stats afcs_checker u_afcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_item_kind    (out_item_kind),
  .out_sample_value (out_sample_value),
  .out_first_max    (out_first_max),
  .out_second_max   (out_second_max),
  .out_first_min    (out_first_min),
  .out_second_min   (out_second_min),
  .out_last_of_run  (out_last_of_run)
);
